@@ rtl/arpeggiator_note_sequencer_macros.svh @@
// Assertion macros for the arpeggiator note sequencer.
`ifndef ARPEGGIATOR_NOTE_SEQUENCER_MACROS_SVH
`define ARPEGGIATOR_NOTE_SEQUENCER_MACROS_SVH
// Implication checked every clock, idle during reset.
`define ARP_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ARP_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/arp_pkg.sv @@
// Package: constants (including the hash multiplier and shift) and types of the arpeggiator.
`timescale 1ns / 1ps
package arp_pkg;
  localparam int MaxNotes = 16;
  localparam int CntW = $clog2(MaxNotes + 1);
  localparam int IdxW = $clog2(MaxNotes);
  localparam int TickW = 48;
  localparam int DivW = 64;
  localparam int QDepth = 2;
  localparam logic [31:0] HashMul = 32'd2654435761;
  localparam int HashShift = 13;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_TPS   = 2'd1,
    REG_VEL   = 2'd2,
    REG_EN    = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_UPDOWN = 2'd2,
    MODE_RANDOM = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [6:0]       note;
    logic [TickW-1:0] tick_time;
  } cmd_t;

  typedef struct packed {
    logic       is_on;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } evt_t;

  typedef struct packed {
    logic [1:0]  pattern_mode;
    logic [15:0] ticks_per_step;
    logic [6:0]  note_velocity;
    logic        enabled;
  } cfg_t;
endpackage

@@ rtl/arp_if.sv @@
// Valid/ready channel interfaces for items, results and configuration.
`timescale 1ns / 1ps
interface arp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] note;
  logic [47:0] tick_time;
  modport source (output valid, kind, note, tick_time, input ready);
  modport sink (input valid, kind, note, tick_time, output ready);
endinterface

interface arp_out_if;
  logic       valid;
  logic       ready;
  logic       is_on;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic       last;
  modport source (output valid, is_on, out_note, out_velocity, last, input ready);
  modport sink (input valid, is_on, out_note, out_velocity, last, output ready);
endinterface

interface arp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/arpeggiator_note_sequencer.sv @@
// Throughput: one beat in service at a time; a two-entry queue buffers input.
// A new step uses the shared radix-2 divider once, or twice if over one note is held.
// Reset (rst, synchronous): empty note set, no step, nothing sounding,
// registers at mode up, 1 tick per step, velocity 100, enabled.
`timescale 1ns / 1ps
module arpeggiator_note_sequencer (
  input logic      clk,
  input logic      rst,
  arp_in_if.sink   in_ch,
  arp_out_if.source out_ch,
  arp_cfg_if.sink  cfg_ch
);
  import arp_pkg::*;
  cmd_t q_data;
  logic q_valid, q_pop;
  cfg_t cfg;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{pattern_mode: MODE_UP, ticks_per_step: 16'd1, note_velocity: 7'd100,
               enabled: 1'b1};
    end else if (cfg_ch.valid) begin
      unique case (reg_t'(cfg_ch.index))
        REG_MODE: cfg.pattern_mode <= cfg_ch.data[1:0];
        REG_TPS:  if (cfg_ch.data != '0) cfg.ticks_per_step <= cfg_ch.data;
        REG_VEL:  cfg.note_velocity <= cfg_ch.data[6:0];
        REG_EN:   cfg.enabled <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  arp_front u_front (.clk, .rst, .in_ch, .q_data, .q_valid, .q_pop);
  arp_back u_back (.clk, .rst, .q_data, .q_valid, .q_pop, .cfg, .out_ch);
endmodule

@@ rtl/arp_front.sv @@
// Front end: accepts beats, drops unused kinds, queues commands.
`timescale 1ns / 1ps
module arp_front (
  input  logic            clk,
  input  logic            rst,
  arp_in_if.sink          in_ch,
  output arp_pkg::cmd_t   q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  import arp_pkg::*;
  `include "arpeggiator_note_sequencer_macros.svh"

  localparam int PtrW = $clog2(QDepth);
  cmd_t            mem [QDepth];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0]   count;
  logic            push;

  assign in_ch.ready = (count != (PtrW+1)'(QDepth));
  assign push = in_ch.valid && in_ch.ready && (kind_t'(in_ch.kind) != KIND_NONE);
  assign q_valid = (count != '0);
  assign q_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{kind: in_ch.kind, note: in_ch.note, tick_time: in_ch.tick_time};
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  `ARP_ASSERT_IMP(a_no_pop_empty, q_pop, q_valid)
  `ARP_ASSERT_IMP(a_count_bound, 1'b1, count <= (PtrW+1)'(QDepth))
  `ARP_ASSERT_NXT(a_push_count, push && !q_pop, count != '0)
endmodule

@@ rtl/arp_divider.sv @@
// Radix-2 restoring divider: 64-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps
module arp_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [arp_pkg::DivW-1:0] dividend,
  input  logic [15:0]              divisor,
  output logic                     done,
  output logic [arp_pkg::DivW-1:0] quotient,
  output logic [16:0]              remainder
);
  import arp_pkg::*;
  logic [$clog2(DivW+1)-1:0] cnt;
  logic                      busy;
  logic [16:0]               trial;
  logic [17:0]               diff;

  assign trial = {remainder[15:0], quotient[DivW-1]};
  assign diff = {1'b0, trial} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        quotient <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (diff[17]) begin
          remainder <= trial;
          quotient <= {quotient[DivW-2:0], 1'b0};
        end else begin
          remainder <= diff[16:0];
          quotient <= {quotient[DivW-2:0], 1'b1};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(DivW+1))'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/arp_back.sv @@
// Back end: note set, step tracking, pattern index and event output.
`timescale 1ns / 1ps
module arp_back (
  input  logic           clk,
  input  logic           rst,
  input  arp_pkg::cmd_t  q_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  arp_pkg::cfg_t  cfg,
  arp_out_if.source      out_ch
);
  import arp_pkg::*;
  `include "arpeggiator_note_sequencer_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_SHIFT = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_HASH  = 10'b0000010000,
    S_HXOR  = 10'b0000100000,
    S_MOD   = 10'b0001000000,
    S_PICK  = 10'b0010000000,
    S_OFF   = 10'b0100000000,
    S_ON    = 10'b1000000000
  } st_t;

  st_t             st;
  logic [6:0]      notes [MaxNotes];
  logic [CntW-1:0] held_count;
  logic [TickW-1:0] current_step;
  logic            step_valid;
  logic [6:0]      sounding_note;
  logic            sounding_valid;
  cmd_t            cmd;
  logic [CntW-1:0] pos;
  logic            found;
  logic [63:0]     h;
  logic [63:0]     md;
  logic [TickW-1:0] step;
  logic [6:0]      chosen;
  logic            send_on;
  logic            hstep;

  logic            div_start, div_start_next, div_done;
  logic [DivW-1:0] div_q;
  logic [16:0]     div_r;
  logic [DivW-1:0] div_a;
  logic [15:0]     div_b;

  arp_divider u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  logic [CntW:0] period;
  logic [6:0]    modn;
  assign period = {held_count, 1'b0} - (CntW+1)'(2);
  assign modn = (cfg.pattern_mode == MODE_UPDOWN) ? 7'(period) : 7'(held_count);

  evt_t       ev;
  logic       ev_valid;
  assign out_ch.valid = ev_valid;
  assign out_ch.is_on = ev.is_on;
  assign out_ch.out_note = ev.out_note;
  assign out_ch.out_velocity = ev.out_velocity;
  assign out_ch.last = ev.last;
  logic ev_free;
  logic ev_load;
  assign ev_free = !ev_valid || out_ch.ready;
  assign ev_load = ((st == S_OFF) || (st == S_ON)) && ev_free;
  assign q_pop = (st == S_IDLE) && q_valid;

  assign div_start_next = ((st == S_IDLE) && q_valid
                           && kind_t'(q_data.kind) == KIND_TICK
                           && cfg.enabled && held_count != '0)
                          || (st == S_MOD);

  // (s + 1) * mul mod 2^64, split into two partial products on the low 32 bits and the upper bits of s + 1
  logic [TickW:0]  sp1;
  logic [63:0]     prod_lo;
  logic [31:0]     prod_hi;
  assign sp1 = {1'b0, step} + (TickW+1)'(1);
  assign prod_lo = {32'b0, sp1[31:0]} * {32'b0, HashMul};
  assign prod_hi = {15'b0, sp1[TickW:32]} * HashMul;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      held_count <= '0;
      step_valid <= 1'b0;
      sounding_valid <= 1'b0;
      sounding_note <= '0;
      current_step <= '0;
      ev_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= div_start_next;
      ev_valid <= ev_load || (ev_valid && !out_ch.ready);
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_data;
            pos <= '0;
            found <= 1'b0;
            unique case (kind_t'(q_data.kind))
              KIND_ON, KIND_OFF: st <= S_SCAN;
              KIND_TICK: begin
                if (!cfg.enabled || held_count == '0) begin
                  step_valid <= 1'b0;
                  if (sounding_valid) begin
                    send_on <= 1'b0;
                    st <= S_OFF;
                  end
                end else begin
                  div_a <= DivW'(q_data.tick_time);
                  div_b <= cfg.ticks_per_step;
                  st <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (pos < held_count && notes[IdxW'(pos)] < cmd.note
              && kind_t'(cmd.kind) == KIND_ON) begin
            pos <= pos + 1'b1;
          end else if (kind_t'(cmd.kind) == KIND_OFF) begin
            if (pos >= held_count) st <= S_IDLE;
            else if (notes[IdxW'(pos)] == cmd.note) begin
              found <= 1'b1;
              st <= S_SHIFT;
            end else pos <= pos + 1'b1;
          end else begin
            if (cmd.note == 7'd0 || held_count == CntW'(MaxNotes)
                || (pos < held_count && notes[IdxW'(pos)] == cmd.note)) st <= S_IDLE;
            else st <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (found) begin
            for (int j = 0; j < MaxNotes - 1; j++)
              if (CntW'(j) >= pos) notes[j] <= notes[j+1];
            held_count <= held_count - 1'b1;
          end else begin
            for (int j = 1; j < MaxNotes; j++)
              if (CntW'(j) > pos) notes[j] <= notes[j-1];
            notes[IdxW'(pos)] <= cmd.note;
            held_count <= held_count + 1'b1;
          end
          st <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            if (step_valid && div_q[TickW-1:0] == current_step) st <= S_IDLE;
            else begin
              step <= div_q[TickW-1:0];
              current_step <= div_q[TickW-1:0];
              step_valid <= 1'b1;
              hstep <= 1'b0;
              md <= div_q;
              if (held_count <= CntW'(1)) st <= S_PICK;
              else if (cfg.pattern_mode == MODE_RANDOM) st <= S_HASH;
              else st <= S_MOD;
            end
          end
        end
        S_HASH: begin
          if (!hstep) begin
            h <= prod_lo;
            hstep <= 1'b1;
          end else begin
            h <= h + {prod_hi, 32'b0};
            st <= S_HXOR;
          end
        end
        S_HXOR: begin
          md <= h ^ (h >> HashShift);
          st <= S_MOD;
        end
        S_MOD: begin
          div_a <= md;
          div_b <= {9'b0, modn};
          st <= S_PICK;
        end
        S_PICK: begin
          if (div_done || held_count <= CntW'(1)) begin
            if (held_count <= CntW'(1)) chosen <= notes[0];
            else if (cfg.pattern_mode == MODE_DOWN)
              chosen <= notes[IdxW'(held_count - 1'b1 - CntW'(div_r))];
            else if (cfg.pattern_mode == MODE_UPDOWN && 7'(div_r) >= 7'(held_count))
              chosen <= notes[IdxW'(period - (CntW+1)'(div_r))];
            else chosen <= notes[IdxW'(div_r)];
            send_on <= 1'b1;
            st <= sounding_valid ? S_OFF : S_ON;
          end
        end
        S_OFF: begin
          if (ev_free) begin
            ev <= '{is_on: 1'b0, out_note: sounding_note, out_velocity: 7'd0,
                    last: !send_on};
            sounding_valid <= 1'b0;
            st <= send_on ? S_ON : S_IDLE;
          end
        end
        S_ON: begin
          if (ev_free) begin
            ev <= '{is_on: 1'b1, out_note: chosen, out_velocity: cfg.note_velocity,
                    last: 1'b1};
            sounding_note <= chosen;
            sounding_valid <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ARP_ASSERT_IMP(a_count_max, 1'b1, held_count <= CntW'(MaxNotes))
  `ARP_ASSERT_NXT(a_on_sounds, st == S_ON && ev_free, sounding_valid)
  `ARP_ASSERT_IMP(a_pop_idle, q_pop, st == S_IDLE)
endmodule
